// ===== rtl/ghp_pkg.sv =====
// ----------------------------------------------------------------------------
// ghp_pkg
// Shared types, codes and constants for the generational handle pool.
// ----------------------------------------------------------------------------
package ghp_pkg;

  localparam int MAX_SLOTS_DEFAULT = 1024;
  localparam int QUEUE_DEPTH       = 2;
  localparam int ITEM_COUNT_RESET  = 1023;
  localparam int ADDR_W            = 3;
  localparam int DATA_W            = 32;

  localparam logic REG_TYPE_TAG   = 1'b0;
  localparam logic REG_ITEM_COUNT = 1'b1;

  localparam logic [2:0] ACT_ADD     = 3'd0;
  localparam logic [2:0] ACT_REMOVE  = 3'd1;
  localparam logic [2:0] ACT_CHECK   = 3'd2;
  localparam logic [2:0] ACT_CLEAR   = 3'd3;
  localparam logic [2:0] ACT_COMPACT = 3'd4;
  localparam logic [2:0] ACT_ITERATE = 3'd5;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FULL  = 3'd1;
  localparam logic [2:0] ST_TYPE  = 3'd2;
  localparam logic [2:0] ST_RANGE = 3'd3;
  localparam logic [2:0] ST_ZERO  = 3'd4;
  localparam logic [2:0] ST_OLD   = 3'd5;
  localparam logic [2:0] ST_NEW   = 3'd6;
  localparam logic [2:0] ST_IDLE  = 3'd7;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_REMOVE,
    OP_CHECK,
    OP_CLEAR,
    OP_COMPACT,
    OP_ITERATE,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [2:0]  pre_status;
    logic [31:0] index;
    logic [15:0] generation;
    logic [9:0]  cursor;
  } item_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_ACC,
    S_CLR,
    S_CMP_RD,
    S_CMP_EV,
    S_IT_RD,
    S_IT_EV
  } back_state_t;

endpackage

// ===== rtl/ghp_front.sv =====
// ----------------------------------------------------------------------------
// ghp_front
// Takes commands, decodes the action and does the register-only handle checks
// (type, range, zero index) before the transaction is queued.
// ----------------------------------------------------------------------------
module ghp_front #(
  parameter int MAX_SLOTS = ghp_pkg::MAX_SLOTS_DEFAULT
) (
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   action,
  input  logic [31:0]                  handle_index,
  input  logic [15:0]                  handle_generation,
  input  logic [15:0]                  handle_type,
  input  logic [9:0]                   cursor,
  input  logic [15:0]                  type_tag,
  input  logic [$clog2(MAX_SLOTS)-1:0] slot_limit,
  input  logic                         q_full,
  input  logic                         initialising,
  output logic                         push,
  output ghp_pkg::item_t               item
);

  ghp_pkg::op_t op;
  logic [2:0]   pre;

  assign busy = q_full | initialising;
  assign push = start & ~busy;

  always_comb begin
    unique case (action)
      ghp_pkg::ACT_ADD:     op = ghp_pkg::OP_ADD;
      ghp_pkg::ACT_REMOVE:  op = ghp_pkg::OP_REMOVE;
      ghp_pkg::ACT_CHECK:   op = ghp_pkg::OP_CHECK;
      ghp_pkg::ACT_CLEAR:   op = ghp_pkg::OP_CLEAR;
      ghp_pkg::ACT_COMPACT: op = ghp_pkg::OP_COMPACT;
      ghp_pkg::ACT_ITERATE: op = ghp_pkg::OP_ITERATE;
      default:              op = ghp_pkg::OP_NOP;
    endcase
  end

  always_comb begin
    pre = ghp_pkg::ST_OK;
    if (op == ghp_pkg::OP_REMOVE || op == ghp_pkg::OP_CHECK) begin
      priority if (handle_type != type_tag) begin
        pre = ghp_pkg::ST_TYPE;
      end else if (handle_index > 32'(slot_limit)) begin
        pre = ghp_pkg::ST_RANGE;
      end else if (handle_index == 32'd0) begin
        pre = ghp_pkg::ST_ZERO;
      end else begin
        pre = ghp_pkg::ST_OK;
      end
    end
  end

  always_comb begin
    item.op         = op;
    item.pre_status = pre;
    item.index      = handle_index;
    item.generation = handle_generation;
    item.cursor     = cursor;
  end

endmodule

// ===== rtl/ghp_queue.sv =====
// ----------------------------------------------------------------------------
// ghp_queue
// Short FIFO of decoded transactions between front and back.
// ----------------------------------------------------------------------------
module ghp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ghp_pkg::item_t push_item,
  input  logic           pop,
  output ghp_pkg::item_t head_item,
  output logic           empty,
  output logic           full
);

  localparam int Depth = ghp_pkg::QUEUE_DEPTH;
  localparam int PW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [PW-1:0] LastPtr = PW'(Depth - 1);

  ghp_pkg::item_t entries [Depth];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [PW:0]    fill;

  assign empty     = (fill == '0);
  assign full      = (fill == (PW+1)'(Depth));
  assign head_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + (PW+1)'(1);
        2'b01:   fill <= fill - (PW+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/ghp_back.sv =====
// ----------------------------------------------------------------------------
// ghp_back
// Slot store and sequencer: add/remove read-modify-write, check read, clear
// and compact sweeps, iterate scan, and the reset initialisation pass.
// ----------------------------------------------------------------------------
module ghp_back #(
  parameter int MAX_SLOTS = ghp_pkg::MAX_SLOTS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [$clog2(MAX_SLOTS)-1:0] slot_limit,
  input  logic [15:0]                  type_tag,
  input  logic                         q_empty,
  input  ghp_pkg::item_t               q_item,
  output logic                         q_pop,
  output logic                         initialising,
  output logic                         done,
  output logic [2:0]                   status,
  output logic [9:0]                   out_index,
  output logic [15:0]                  out_generation,
  output logic [15:0]                  out_type,
  output logic                         found,
  output logic [9:0]                   in_use_count
);

  localparam int IW   = $clog2(MAX_SLOTS);
  localparam int RstN = (ghp_pkg::ITEM_COUNT_RESET > MAX_SLOTS - 1) ?
                        MAX_SLOTS - 1 : ghp_pkg::ITEM_COUNT_RESET;
  localparam logic [IW-1:0] LastSlot = IW'(MAX_SLOTS - 1);
  localparam logic [IW-1:0] RstLimit = IW'(RstN);
  localparam logic [IW-1:0] One      = IW'(1);

  logic            mem_busy [MAX_SLOTS];
  logic [IW-1:0]   mem_link [MAX_SLOTS];
  logic [15:0]     mem_gen  [MAX_SLOTS];

  logic [IW-1:0]   rd_addr;
  logic            rd_busy;
  logic [IW-1:0]   rd_link;
  logic [15:0]     rd_gen;
  logic [IW-1:0]   wr_addr;
  logic            we_busy, we_link, we_gen;
  logic            wd_busy;
  logic [IW-1:0]   wd_link;
  logic [15:0]     wd_gen;

  ghp_pkg::back_state_t state, state_next;
  logic [IW-1:0]   ctr, ctr_next;
  ghp_pkg::item_t  job, job_next;
  logic [IW-1:0]   free_head, free_head_next;
  logic [9:0]      busy_total, busy_total_next;

  logic            emit;
  logic [2:0]      r_status;
  logic [9:0]      r_index;
  logic [15:0]     r_gen;
  logic [15:0]     r_type;
  logic            r_found;
  logic [2:0]      check_status;

  function automatic logic [IW-1:0] relink(input logic [IW-1:0] i,
                                           input logic [IW-1:0] lim);
    relink = (i != '0 && i < lim) ? i + One : '0;
  endfunction

  always_ff @(posedge clk) begin
    if (we_busy) begin
      mem_busy[wr_addr] <= wd_busy;
    end
    if (we_link) begin
      mem_link[wr_addr] <= wd_link;
    end
    if (we_gen) begin
      mem_gen[wr_addr] <= wd_gen;
    end
    rd_busy <= mem_busy[rd_addr];
    rd_link <= mem_link[rd_addr];
    rd_gen  <= mem_gen[rd_addr];
  end

  assign initialising = (state == ghp_pkg::S_INIT);

  always_comb begin
    priority if (job.generation < rd_gen) begin
      check_status = ghp_pkg::ST_OLD;
    end else if (job.generation > rd_gen) begin
      check_status = ghp_pkg::ST_NEW;
    end else if (!rd_busy) begin
      check_status = ghp_pkg::ST_IDLE;
    end else begin
      check_status = ghp_pkg::ST_OK;
    end
  end

  always_comb begin
    state_next      = state;
    ctr_next        = ctr;
    job_next        = job;
    free_head_next  = free_head;
    busy_total_next = busy_total;
    q_pop           = 1'b0;
    rd_addr         = ctr;
    wr_addr         = ctr;
    we_busy         = 1'b0;
    we_link         = 1'b0;
    we_gen          = 1'b0;
    wd_busy         = 1'b0;
    wd_link         = '0;
    wd_gen          = '0;
    emit            = 1'b0;
    r_status        = ghp_pkg::ST_OK;
    r_index         = '0;
    r_gen           = '0;
    r_type          = '0;
    r_found         = 1'b0;

    unique case (state)
      ghp_pkg::S_INIT: begin
        we_busy = 1'b1;
        we_link = 1'b1;
        we_gen  = 1'b1;
        wd_link = relink(ctr, RstLimit);
        if (ctr == LastSlot) begin
          free_head_next  = (RstLimit != '0) ? One : '0;
          busy_total_next = '0;
          ctr_next        = '0;
          state_next      = ghp_pkg::S_IDLE;
        end else begin
          ctr_next = ctr + One;
        end
      end

      ghp_pkg::S_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          job_next = q_item;
          unique case (q_item.op)
            ghp_pkg::OP_ADD: begin
              rd_addr  = free_head;
              ctr_next = free_head;
              if (free_head == '0 || free_head > slot_limit) begin
                emit     = 1'b1;
                r_status = ghp_pkg::ST_FULL;
              end else begin
                state_next = ghp_pkg::S_ACC;
              end
            end
            ghp_pkg::OP_REMOVE, ghp_pkg::OP_CHECK: begin
              rd_addr  = IW'(q_item.index);
              ctr_next = IW'(q_item.index);
              if (q_item.pre_status != ghp_pkg::ST_OK) begin
                emit     = 1'b1;
                r_status = q_item.pre_status;
              end else begin
                state_next = ghp_pkg::S_ACC;
              end
            end
            ghp_pkg::OP_CLEAR: begin
              ctr_next   = '0;
              state_next = ghp_pkg::S_CLR;
            end
            ghp_pkg::OP_COMPACT: begin
              free_head_next = '0;
              if (slot_limit == '0) begin
                emit = 1'b1;
              end else begin
                ctr_next   = slot_limit;
                state_next = ghp_pkg::S_CMP_RD;
              end
            end
            ghp_pkg::OP_ITERATE: begin
              if (32'(q_item.cursor) >= 32'(slot_limit)) begin
                emit = 1'b1;
              end else begin
                ctr_next   = IW'(q_item.cursor) + One;
                state_next = ghp_pkg::S_IT_RD;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      ghp_pkg::S_ACC: begin
        emit = 1'b1;
        unique case (job.op)
          ghp_pkg::OP_ADD: begin
            we_busy         = 1'b1;
            wd_busy         = 1'b1;
            free_head_next  = rd_link;
            busy_total_next = busy_total + 10'd1;
            r_index         = 10'(ctr);
            r_gen           = rd_gen;
            r_type          = type_tag;
          end
          ghp_pkg::OP_REMOVE: begin
            r_status = check_status;
            if (check_status == ghp_pkg::ST_OK) begin
              we_busy         = 1'b1;
              we_link         = 1'b1;
              we_gen          = 1'b1;
              wd_busy         = 1'b0;
              wd_link         = free_head;
              wd_gen          = rd_gen + 16'd1;
              free_head_next  = ctr;
              busy_total_next = busy_total - 10'd1;
            end
          end
          ghp_pkg::OP_CHECK: begin
            r_status = check_status;
          end
          default: begin
            r_status = ghp_pkg::ST_OK;
          end
        endcase
      end

      ghp_pkg::S_CLR: begin
        we_busy = 1'b1;
        we_link = 1'b1;
        wd_link = relink(ctr, slot_limit);
        if (ctr == LastSlot) begin
          free_head_next  = (slot_limit != '0) ? One : '0;
          busy_total_next = '0;
          emit            = 1'b1;
        end else begin
          ctr_next = ctr + One;
        end
      end

      ghp_pkg::S_CMP_RD: begin
        state_next = ghp_pkg::S_CMP_EV;
      end

      ghp_pkg::S_CMP_EV: begin
        if (!rd_busy) begin
          we_link        = 1'b1;
          wd_link        = free_head;
          free_head_next = ctr;
        end
        if (ctr == One) begin
          emit = 1'b1;
        end else begin
          ctr_next   = ctr - One;
          state_next = ghp_pkg::S_CMP_RD;
        end
      end

      ghp_pkg::S_IT_RD: begin
        state_next = ghp_pkg::S_IT_EV;
      end

      ghp_pkg::S_IT_EV: begin
        if (rd_busy) begin
          emit    = 1'b1;
          r_found = 1'b1;
          r_index = 10'(ctr);
          r_gen   = rd_gen;
          r_type  = type_tag;
        end else if (ctr == slot_limit) begin
          emit = 1'b1;
        end else begin
          ctr_next   = ctr + One;
          state_next = ghp_pkg::S_IT_RD;
        end
      end

      default: begin
        state_next = ghp_pkg::S_IDLE;
      end
    endcase

    if (emit) begin
      state_next = ghp_pkg::S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ghp_pkg::S_INIT;
      ctr        <= '0;
      free_head  <= '0;
      busy_total <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      ctr        <= ctr_next;
      free_head  <= free_head_next;
      busy_total <= busy_total_next;
      done       <= emit;
    end
  end

  always_ff @(posedge clk) begin
    job <= job_next;
    if (emit) begin
      status         <= r_status;
      out_index      <= r_index;
      out_generation <= r_gen;
      out_type       <= r_type;
      found          <= r_found;
      in_use_count   <= busy_total_next;
    end
  end

endmodule

// ===== rtl/generational_handle_pool_core.sv =====
// ----------------------------------------------------------------------------
// generational_handle_pool_core
// Allocator of generational handles over a slot store, with an APB register
// port for the type tag and the usable slot count.
// ----------------------------------------------------------------------------
//  channel   | handshake                       | payload
//  ----------+---------------------------------+-----------------------------
//  command   | start in, busy out              | action, handle_*, cursor
//  result    | done strobe, one cycle          | status, out_*, found,
//            |                                 | in_use_count
//  register  | psel/penable/pwrite, pready = 1 | paddr, pwdata, prdata
//
//  Add, remove and check read the store, then add and remove write back.
//  Clear rewrites every slot in turn; compact and iterate visit the slots
//  one by one, each visit a store read then a decide.
//  Faults caught on the registers alone, unused actions and exhausted iterates
//  are answered from idle. Two transactions can queue behind the one running.
//  After reset the store is initialised slot by slot with busy high.
//  Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module generational_handle_pool_core #(
  parameter int MAX_SLOTS = ghp_pkg::MAX_SLOTS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ghp_pkg::ADDR_W-1:0] paddr,
  input  logic [ghp_pkg::DATA_W-1:0] pwdata,
  output logic [ghp_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  input  logic                       start,
  output logic                       busy,
  input  logic [2:0]                 action,
  input  logic [31:0]                handle_index,
  input  logic [15:0]                handle_generation,
  input  logic [15:0]                handle_type,
  input  logic [9:0]                 cursor,
  output logic                       done,
  output logic [2:0]                 status,
  output logic [9:0]                 out_index,
  output logic [15:0]                out_generation,
  output logic [15:0]                out_type,
  output logic                       found,
  output logic [9:0]                 in_use_count
);

  localparam int IW = $clog2(MAX_SLOTS);

  logic [15:0]     pool_type_tag;
  logic [9:0]      item_count;
  logic [IW-1:0]   slot_limit;
  logic            reg_sel;
  logic            push, pop, q_empty, q_full, initialising;
  ghp_pkg::item_t  push_item, head_item;

  assign pready  = 1'b1;
  assign reg_sel = paddr[ghp_pkg::ADDR_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_type_tag <= '0;
      item_count    <= 10'(ghp_pkg::ITEM_COUNT_RESET);
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        ghp_pkg::REG_TYPE_TAG:   pool_type_tag <= pwdata[15:0];
        ghp_pkg::REG_ITEM_COUNT: item_count    <= pwdata[9:0];
        default:                 pool_type_tag <= pool_type_tag;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      ghp_pkg::REG_TYPE_TAG:   prdata = {16'd0, pool_type_tag};
      ghp_pkg::REG_ITEM_COUNT: prdata = {22'd0, item_count};
      default:                 prdata = '0;
    endcase
  end

  always_comb begin
    if (32'(item_count) > 32'(MAX_SLOTS - 1)) begin
      slot_limit = IW'(MAX_SLOTS - 1);
    end else begin
      slot_limit = IW'(item_count);
    end
  end

  ghp_front #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_front (
    .start             (start),
    .busy              (busy),
    .action            (action),
    .handle_index      (handle_index),
    .handle_generation (handle_generation),
    .handle_type       (handle_type),
    .cursor            (cursor),
    .type_tag          (pool_type_tag),
    .slot_limit        (slot_limit),
    .q_full            (q_full),
    .initialising      (initialising),
    .push              (push),
    .item              (push_item)
  );

  ghp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .empty     (q_empty),
    .full      (q_full)
  );

  ghp_back #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .slot_limit     (slot_limit),
    .type_tag       (pool_type_tag),
    .q_empty        (q_empty),
    .q_item         (head_item),
    .q_pop          (pop),
    .initialising   (initialising),
    .done           (done),
    .status         (status),
    .out_index      (out_index),
    .out_generation (out_generation),
    .out_type       (out_type),
    .found          (found),
    .in_use_count   (in_use_count)
  );

endmodule
